@@ rtl/lag_delta_xor_codec_top_assert.svh @@
// Assertion macros used by the codec RTL.
`ifndef LAG_DELTA_XOR_CODEC_TOP_ASSERT_SVH
`define LAG_DELTA_XOR_CODEC_TOP_ASSERT_SVH

// Same-cycle implication.
`define LXC_ASSERT_NOW(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("lxc assertion failed");

// Next-cycle implication.
`define LXC_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("lxc assertion failed");

`endif

@@ rtl/lxc_pkg.sv @@
package lxc_pkg;

   localparam int unsigned MAX_LAG_DEFAULT = 4096;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CSR_DATA_W = 13;
   localparam int unsigned MODE_W = 2;
   localparam int unsigned LAG_REG_W = 13;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DIR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LAG  = 2'd2;

   // transform modes
   localparam logic [MODE_W-1:0] MODE_TRANSITION = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PERIOD_SUB = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PERIOD_XOR = 2'd2;

   // direction codes
   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

endpackage

@@ rtl/lxc_ring.sv @@
module lxc_ring #(
   parameter int unsigned DEPTH  = lxc_pkg::MAX_LAG_DEFAULT,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [lxc_pkg::BYTE_W-1:0]  rd_data,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [lxc_pkg::BYTE_W-1:0]  wr_data
);

   logic [lxc_pkg::BYTE_W-1:0] mem [0:DEPTH-1];
   logic [lxc_pkg::BYTE_W-1:0] rd_data_ff;

   // read returns the old contents on a same-address write; the caller forwards
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/lag_delta_xor_codec_top.sv @@
// Byte-stream delta / xor filter with a programmable distance.
// req_*: one byte per beat in, tlast ends a stream and returns the position to
//   the start. rsp_*: one byte per beat out, tlast copied from the input beat.
// csr_*: register writes (index 0 mode, 1 direction, 2 lag); always ready,
//   only to be used while the block is idle. Writes keep the stream position.
// A beat accepted passes the stage 1 and output registers on to rsp_*.
// Throughput: one beat per cycle while rsp_tready is high; the ring is a
//   one-port-write, one-port-read memory, read at accept and written as the
//   beat leaves stage 1, forwarded when the next beat reads that slot (lag 1).
// Reset: clears the registers to mode 0, encode, lag 1, and clears pointer,
//   fill count and all valid flags. The ring contents are not cleared; a
//   slot's contents are not used before it has been written.
// Stall: when rsp_tready is low the output register holds, the middle stage
//   fills, and req_tready drops until the output drains. No beat is lost.
module lag_delta_xor_codec_top #(
   parameter int unsigned MAX_LAG = lxc_pkg::MAX_LAG_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // input stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] data_byte
   input  logic                            req_tlast,   // last_byte
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [7:0]                      rsp_tdata,   // [7:0] out_byte
   output logic                            rsp_tlast,   // out_last
   // register writes
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lxc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lxc_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int unsigned PTR_W = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
   localparam int unsigned LAG_W = $clog2(MAX_LAG + 1);
   localparam int unsigned CMP_W = (LAG_W > lxc_pkg::LAG_REG_W) ? LAG_W : lxc_pkg::LAG_REG_W;

   // ---- configuration registers ----
   logic [lxc_pkg::MODE_W-1:0]    mode_ff;
   logic                          dir_ff;
   logic [lxc_pkg::LAG_REG_W-1:0] lag_reg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= lxc_pkg::MODE_TRANSITION;
         dir_ff     <= lxc_pkg::DIR_ENCODE;
         lag_reg_ff <= lxc_pkg::LAG_REG_W'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            lxc_pkg::REG_MODE: mode_ff    <= csr_data[lxc_pkg::MODE_W-1:0];
            lxc_pkg::REG_DIR:  dir_ff     <= csr_data[0];
            lxc_pkg::REG_LAG:  lag_reg_ff <= csr_data[lxc_pkg::LAG_REG_W-1:0];
            default: begin
               // unused index: ignored
            end
         endcase
      end
   end

   // effective lag: 1 in transition mode, else clamped to 1..MAX_LAG
   logic [CMP_W-1:0] lag_cmp;
   logic [LAG_W-1:0] lag;

   always_comb begin
      lag_cmp = CMP_W'(lag_reg_ff);
      priority if (mode_ff == lxc_pkg::MODE_TRANSITION) begin
         lag_cmp = CMP_W'(1);
      end else if (lag_cmp == '0) begin
         lag_cmp = CMP_W'(1);
      end else if (lag_cmp > CMP_W'(MAX_LAG)) begin
         lag_cmp = CMP_W'(MAX_LAG);
      end else begin
         lag_cmp = CMP_W'(lag_reg_ff);
      end
   end

   assign lag = LAG_W'(lag_cmp);

   // ---- handshake and pipeline control ----
   logic s1_valid_ff;
   logic out_valid_ff;
   logic s1_adv;
   logic accept;

   assign s1_adv     = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;

   // ---- stream position ----
   logic [PTR_W-1:0] ptr_ff;
   logic [LAG_W-1:0] fill_ff;
   logic [PTR_W-1:0] pos;
   logic [LAG_W-1:0] pos_inc;
   logic             full;
   logic [PTR_W-1:0] ptr_in;
   logic [LAG_W-1:0] fill_in;

   always_comb begin
      // pointer left beyond a shortened lag wraps to slot 0
      pos     = (LAG_W'(ptr_ff) >= lag) ? '0 : ptr_ff;
      pos_inc = LAG_W'(pos) + LAG_W'(1);
      full    = (fill_ff >= lag);
      if (req_tlast) begin
         ptr_in  = '0;
         fill_in = '0;
      end else begin
         ptr_in  = (pos_inc >= lag) ? '0 : PTR_W'(pos_inc);
         fill_in = full ? lag : fill_ff + LAG_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         fill_ff <= '0;
      end else if (accept) begin
         ptr_ff  <= ptr_in;
         fill_ff <= fill_in;
      end
   end

   // ---- stage 1: ring read in flight ----
   logic [7:0]       s1_byte_ff;
   logic             s1_last_ff;
   logic [PTR_W-1:0] s1_addr_ff;
   logic             s1_full_ff;
   logic             fwd_ff;
   logic [7:0]       fwd_byte_ff;
   logic [7:0]       ring_rd;
   logic [7:0]       ref_byte;
   logic [7:0]       res_byte;
   logic [7:0]       plain_byte;

   always_comb begin
      ref_byte = fwd_ff ? fwd_byte_ff : ring_rd;
      if (!s1_full_ff) begin
         res_byte = s1_byte_ff;
      end else if (mode_ff == lxc_pkg::MODE_PERIOD_XOR) begin
         res_byte = s1_byte_ff ^ ref_byte;
      end else if (dir_ff == lxc_pkg::DIR_ENCODE) begin
         res_byte = s1_byte_ff - ref_byte;
      end else begin
         res_byte = s1_byte_ff + ref_byte;
      end
      plain_byte = (dir_ff == lxc_pkg::DIR_ENCODE) ? s1_byte_ff : res_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
            // slot being written this edge is the slot just read: bypass
            fwd_ff      <= s1_adv && (s1_addr_ff == pos);
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
            fwd_ff      <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff  <= req_tdata;
         s1_last_ff  <= req_tlast;
         s1_addr_ff  <= pos;
         s1_full_ff  <= full;
         fwd_byte_ff <= plain_byte;
      end
   end

   lxc_ring #(
      .DEPTH  (MAX_LAG),
      .ADDR_W (PTR_W)
   ) u_ring (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (pos),
      .rd_data (ring_rd),
      .wr_en   (s1_adv),
      .wr_addr (s1_addr_ff),
      .wr_data (plain_byte)
   );

   // ---- output register ----
   logic [7:0] out_byte_ff;
   logic       out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_byte_ff <= res_byte;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;

   // ---- assertions ----
   `include "lag_delta_xor_codec_top_assert.svh"

   `LXC_ASSERT_NOW(a_stall_blocks_input, clock, reset,
      s1_valid_ff && out_valid_ff && !rsp_tready, !req_tready)
   `LXC_ASSERT_NOW(a_fill_bounded, clock, reset,
      1'b1, fill_ff <= LAG_W'(MAX_LAG))
   `LXC_ASSERT_NEXT(a_last_resets_pos, clock, reset,
      accept && req_tlast, ptr_ff == '0 && fill_ff == '0)
   `LXC_ASSERT_NOW(a_fwd_needs_item, clock, reset,
      fwd_ff, s1_valid_ff)

endmodule
